@@ hw/rtl/cgs_pkg.sv @@
// Shared constants and types of the checkpoint graph supervisor.
package cgs_pkg;

  localparam int unsigned Checkpoints = 16;
  localparam int unsigned IdW         = 4;
  localparam int unsigned StampW      = 64;
  localparam int unsigned MaskW       = 16;
  localparam logic [MaskW-1:0] IdMask = MaskW'((32'd1 << Checkpoints) - 32'd1);

  // Event codes.
  localparam logic [2:0] FnCheckpoint = 3'd0;
  localparam logic [2:0] FnActivate   = 3'd1;
  localparam logic [2:0] FnDeactivate = 3'd2;
  localparam logic [2:0] FnRecover    = 3'd3;
  localparam logic [2:0] FnDataLoss   = 3'd4;
  localparam logic [2:0] FnSync       = 3'd5;

  // Supervision status codes.
  localparam logic [1:0] StDeact   = 2'd0;
  localparam logic [1:0] StOk      = 2'd1;
  localparam logic [1:0] StExpired = 2'd2;

  // Expiry cause codes.
  localparam logic [1:0] CauseNone    = 2'd0;
  localparam logic [1:0] CauseDataLoss = 2'd1;
  localparam logic [1:0] CauseInvalid = 2'd2;

  // Register map, 64-bit registers at byte address 8*index.
  localparam int unsigned RegAddrW = 6;
  localparam logic [2:0] RegSucc0  = 3'd0;
  localparam logic [2:0] RegSucc1  = 3'd1;
  localparam logic [2:0] RegSucc2  = 3'd2;
  localparam logic [2:0] RegSucc3  = 3'd3;
  localparam logic [2:0] RegEntry  = 3'd4;
  localparam logic [2:0] RegFinal  = 3'd5;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;
  localparam int unsigned QueueCntW  = 3;

  typedef struct packed {
    logic [3:0][63:0] succ_rows;
    logic [MaskW-1:0] entry_mask;
    logic [MaskW-1:0] final_mask;
  } cgs_cfg_t;

  // One queued transaction record; recovery carries two results in one record.
  typedef struct packed {
    logic [1:0]        status;
    logic [1:0]        cause;
    logic              pos_valid;
    logic [IdW-1:0]    pos_id;
    logic [IdW-1:0]    off_id;
    logic              two;
    logic [StampW-1:0] stamp_a;
    logic [StampW-1:0] stamp_b;
  } cgs_entry_t;

endpackage

@@ hw/rtl/cgs_regs.sv @@
// APB configuration registers: successor table, entry and final masks.
module cgs_regs import cgs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [RegAddrW-1:0] paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output cgs_cfg_t            cfg_o
);

  logic [3:0][63:0] succ_q;
  logic [MaskW-1:0] entry_q;
  logic [MaskW-1:0] final_q;
  logic [2:0]       index;
  logic             wr_en;

  assign index  = paddr[RegAddrW-1:3];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      succ_q  <= '0;
      entry_q <= '0;
      final_q <= '0;
    end else if (wr_en) begin
      unique case (index) inside
        RegSucc0, RegSucc1, RegSucc2, RegSucc3: begin
          succ_q[index[1:0]] <= pwdata;
        end
        RegEntry: entry_q <= pwdata[MaskW-1:0];
        RegFinal: final_q <= pwdata[MaskW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index) inside
      RegSucc0, RegSucc1, RegSucc2, RegSucc3: prdata = succ_q[index[1:0]];
      RegEntry: prdata = {{(64-MaskW){1'b0}}, entry_q};
      RegFinal: prdata = {{(64-MaskW){1'b0}}, final_q};
      default:  prdata = '0;
    endcase
  end

  assign cfg_o.succ_rows  = succ_q;
  assign cfg_o.entry_mask = entry_q;
  assign cfg_o.final_mask = final_q;

endmodule

@@ hw/rtl/cgs_front.sv @@
// Front end: accepts events, updates supervision state, queues status switches.
module cgs_front import cgs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        func_i,
  input  logic [IdW-1:0]    checkpoint_id_i,
  input  logic [StampW-1:0] stamp_i,
  input  cgs_cfg_t          cfg_i,
  input  logic              queue_ready_i,
  output logic              push_o,
  output cgs_entry_t        entry_o
);

  logic [1:0]        status_q, status_d;
  logic              running_q, running_d;
  logic [IdW-1:0]    pos_q, pos_d;
  logic [StampW-1:0] rec_q, rec_d;
  logic [StampW-1:0] sync_q, sync_d;

  logic              accept;
  logic              emit;
  logic              ok;
  logic [MaskW-1:0]  id_bit;
  logic [63:0]       row;
  logic [MaskW-1:0]  succ;

  assign in_ready_o = queue_ready_i;
  assign accept     = in_valid_i & queue_ready_i;
  assign push_o     = accept & emit;

  assign id_bit = MaskW'(1) << checkpoint_id_i;
  assign row    = cfg_i.succ_rows[pos_q[3:2]];
  assign succ   = MaskW'(row >> {pos_q[1:0], 4'b0000}) & IdMask;

  always_comb begin
    status_d  = status_q;
    running_d = running_q;
    pos_d     = pos_q;
    rec_d     = rec_q;
    sync_d    = sync_q;
    emit      = 1'b0;
    ok        = 1'b0;
    entry_o   = '0;
    case (func_i)
      FnCheckpoint: begin
        if (status_q == StOk) begin
          rec_d = stamp_i;
          if (!running_q) begin
            ok = (cfg_i.entry_mask & IdMask & id_bit) != '0;
            if (ok) begin
              running_d = 1'b1;
              pos_d     = checkpoint_id_i;
            end
          end else begin
            ok = (succ & id_bit) != '0;
            if (ok) begin
              pos_d = checkpoint_id_i;
              if ((cfg_i.final_mask & IdMask & id_bit) != '0) begin
                running_d = 1'b0;
              end
            end
          end
          if (!ok) begin
            // The graph keeps its position so the report shows where it stood.
            status_d          = StExpired;
            emit              = 1'b1;
            entry_o.status    = StExpired;
            entry_o.cause     = CauseInvalid;
            entry_o.pos_valid = running_q;
            entry_o.pos_id    = running_q ? pos_q : '0;
            entry_o.off_id    = checkpoint_id_i;
            entry_o.stamp_a   = stamp_i;
          end
        end
      end
      FnActivate: begin
        if (status_q == StDeact) begin
          rec_d           = stamp_i;
          status_d        = StOk;
          emit            = 1'b1;
          entry_o.status  = StOk;
          entry_o.stamp_a = stamp_i;
        end
      end
      FnDeactivate: begin
        if (status_q != StDeact) begin
          rec_d           = stamp_i;
          status_d        = StDeact;
          running_d       = 1'b0;
          pos_d           = '0;
          emit            = 1'b1;
          entry_o.status  = StDeact;
          entry_o.stamp_a = stamp_i;
        end
      end
      FnRecover: begin
        rec_d           = stamp_i;
        status_d        = StOk;
        running_d       = 1'b0;
        pos_d           = '0;
        emit            = 1'b1;
        entry_o.status  = StOk;
        entry_o.two     = 1'b1;
        entry_o.stamp_a = rec_q;
        entry_o.stamp_b = stamp_i;
      end
      FnDataLoss: begin
        rec_d = (stamp_i == '0) ? sync_q : stamp_i;
        if (status_q != StExpired) begin
          status_d        = StExpired;
          emit            = 1'b1;
          entry_o.status  = StExpired;
          entry_o.cause   = CauseDataLoss;
          entry_o.stamp_a = rec_d;
        end
      end
      FnSync: sync_d = stamp_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= StDeact;
      running_q <= 1'b0;
      pos_q     <= '0;
      rec_q     <= '0;
      sync_q    <= '0;
    end else if (accept) begin
      status_q  <= status_d;
      running_q <= running_d;
      pos_q     <= pos_d;
      rec_q     <= rec_d;
      sync_q    <= sync_d;
    end
  end

endmodule

@@ hw/rtl/cgs_back.sv @@
// Back end: record queue and output register that expands recovery into two results.
module cgs_back import cgs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cgs_entry_t        entry_i,
  output logic              push_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [1:0]        cause_o,
  output logic [StampW-1:0] event_stamp_o,
  output logic              position_valid_o,
  output logic [IdW-1:0]    position_id_o,
  output logic [IdW-1:0]    offending_id_o,
  output logic              last_o
);

  cgs_entry_t queue_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 phase_q;
  logic                 load, nonempty, pop, first_half;
  cgs_entry_t           head;

  logic              valid_q;
  logic [1:0]        status_q, cause_q;
  logic [StampW-1:0] stamp_q;
  logic              pv_q, last_q;
  logic [IdW-1:0]    pos_q, off_q;

  assign head         = queue_q[rd_q];
  assign nonempty     = count_q != '0;
  assign push_ready_o = count_q != QueueCntW'(QueueDepth);
  assign load         = !valid_q || out_ready_i;
  assign first_half   = head.two && !phase_q;
  assign pop          = load && nonempty && !first_half;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      queue_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
      phase_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (load) begin
        valid_q <= nonempty;
        if (nonempty) begin
          phase_q <= first_half;
        end
      end
    end
  end

  // Payload of the output register. The first half of a recovery record is the
  // deactivated result with the stamp recorded before the recovery.
  always_ff @(posedge clk_i) begin
    if (load && nonempty) begin
      status_q <= first_half ? StDeact : head.status;
      cause_q  <= head.cause;
      stamp_q  <= (head.two && phase_q) ? head.stamp_b : head.stamp_a;
      pv_q     <= head.pos_valid;
      pos_q    <= head.pos_id;
      off_q    <= head.off_id;
      last_q   <= !first_half;
    end
  end

  assign out_valid_o      = valid_q;
  assign status_o         = status_q;
  assign cause_o          = cause_q;
  assign event_stamp_o    = stamp_q;
  assign position_valid_o = pv_q;
  assign position_id_o    = pos_q;
  assign offending_id_o   = off_q;
  assign last_o           = last_q;

endmodule

@@ hw/rtl/checkpoint_graph_supervisor.sv @@
// Top level of the checkpoint graph supervisor.
// The accepting edge queues a status switch; the output register loads it from the queue head.
// Throughput: one event per cycle while the queue has room; a recovery yields two results.
// The input stalls while the four-entry queue is full, after a held output or many recoveries.
// Events that cause no status switch are accepted and produce nothing.
// Reset deactivates and clears the graph, both stamps, the configuration and queue control.
module checkpoint_graph_supervisor import cgs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [RegAddrW-1:0] paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          func_i,
  input  logic [IdW-1:0]      checkpoint_id_i,
  input  logic [StampW-1:0]   stamp_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [1:0]          cause_o,
  output logic [StampW-1:0]   event_stamp_o,
  output logic                position_valid_o,
  output logic [IdW-1:0]      position_id_o,
  output logic [IdW-1:0]      offending_id_o,
  output logic                last_o
);

  cgs_cfg_t   cfg;
  cgs_entry_t entry;
  logic       push;
  logic       push_ready;

  cgs_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  cgs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .checkpoint_id_i(checkpoint_id_i),
    .stamp_i        (stamp_i),
    .cfg_i          (cfg),
    .queue_ready_i  (push_ready),
    .push_o         (push),
    .entry_o        (entry)
  );

  cgs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .entry_i         (entry),
    .push_ready_o    (push_ready),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .cause_o         (cause_o),
    .event_stamp_o   (event_stamp_o),
    .position_valid_o(position_valid_o),
    .position_id_o   (position_id_o),
    .offending_id_o  (offending_id_o),
    .last_o          (last_o)
  );

  // Only the first half of a recovery is a non-final result, and it is always deactivated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == StDeact)
    else $error("non-final result is not a deactivation");

  // A cause is reported exactly when the status expires.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((cause_o != CauseNone) == (status_o == StExpired)))
    else $error("cause does not match status");

  // Position fields are only used by an invalid transition.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (position_valid_o || position_id_o != '0) |-> cause_o == CauseInvalid)
    else $error("position reported outside an invalid transition");

  // The queue can only fill up while a result waits at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with an empty output register");

endmodule
